FILE: rtl/sliding_median_filter_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef SLIDING_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define SMF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, sampled on clock, off during reset
`define SMF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: rtl/smf_pkg.sv
`default_nettype none
package smf_pkg;

   // number of samples in the window (1 to 15)
   localparam int WINDOW = 5;
   localparam int SAMPLE_W = 32;
   localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MEDIAN_IDX = WINDOW / 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [AGE_W-1:0] age_type;

   localparam age_type AGE_OLDEST = AGE_W'(WINDOW - 1);
   localparam age_type AGE_ONE = AGE_W'(1);

   // what one cell shows its neighbours
   typedef struct packed {
      sample_type value;
      age_type    age;
      logic       gt;        // value is greater than the incoming sample
      logic       evict_le;  // oldest entry sits at or below this cell
   } cell_link_type;

   // below the lowest cell: nothing greater, nothing evicted
   localparam cell_link_type LINK_FLOOR = '{value: '0, age: '0, gt: 1'b0, evict_le: 1'b0};
   // above the highest cell: acts as plus infinity
   localparam cell_link_type LINK_CEILING = '{value: '0, age: '0, gt: 1'b1, evict_le: 1'b1};

endpackage
`default_nettype wire

FILE: rtl/sliding_median_filter_unit.sv
// Timing: the median of an item is registered and appears on rsp in the cycle after it is taken.
// Throughput: one item per cycle unless a result waits on rsp; the sorted
// chain of cells updates together and the output register frees as rsp takes its item.
// Reset: synchronous, active high; window holds zeros, no result pending.
`default_nettype none
module sliding_median_filter_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire smf_pkg::sample_type req_tdata,   // [31:0] sample
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output smf_pkg::sample_type      rsp_tdata    // [31:0] median
);
   import smf_pkg::*;

   cell_link_type links [WINDOW];
   sample_type    next_values [WINDOW];
   logic          req_take;
   logic          rsp_valid_ff, rsp_valid_in;
   sample_type    rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   // sorted chain, ascending from cell 0
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      cell_link_type lower_link, upper_link;
      if (i == 0) begin : g_lo
         assign lower_link = LINK_FLOOR;
      end else begin : g_lo
         assign lower_link = links[i-1];
      end
      if (i == WINDOW - 1) begin : g_hi
         assign upper_link = LINK_CEILING;
      end else begin : g_hi
         assign upper_link = links[i+1];
      end
      smf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (req_take),
         .sample     (req_tdata),
         .reset_age  (AGE_W'(i)),
         .lower      (lower_link),
         .upper      (upper_link),
         .link       (links[i]),
         .next_value (next_values[i])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = next_values[MEDIAN_IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/smf_cell.sv
`default_nettype none
// One slot of the sorted window. Drops the oldest entry and makes room
// for the new sample using only its own and its neighbours' state.
module smf_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire smf_pkg::sample_type    sample,
   input  wire smf_pkg::age_type       reset_age,
   input  wire smf_pkg::cell_link_type lower,
   input  wire smf_pkg::cell_link_type upper,
   output smf_pkg::cell_link_type      link,
   output smf_pkg::sample_type         next_value
);
   import smf_pkg::*;

   sample_type value_ff, value_in;
   age_type    age_ff, age_in;
   logic       own_gt, own_evict;
   sample_type self_value, low_value;
   age_type    self_age, low_age;
   logic       self_gt, low_gt;

   // local compare and eviction mark
   always_comb begin
      own_gt    = value_ff > sample;
      own_evict = age_ff == AGE_OLDEST;
      link.value    = value_ff;
      link.age      = age_ff;
      link.gt       = own_gt;
      link.evict_le = lower.evict_le | own_evict;
   end

   // entries at this slot and the one below once the oldest is removed
   always_comb begin
      if (link.evict_le) begin
         self_value = upper.value;
         self_age   = upper.age;
         self_gt    = upper.gt;
      end else begin
         self_value = value_ff;
         self_age   = age_ff;
         self_gt    = own_gt;
      end
      if (lower.evict_le) begin
         low_value = value_ff;
         low_age   = age_ff;
         low_gt    = own_gt;
      end else begin
         low_value = lower.value;
         low_age   = lower.age;
         low_gt    = lower.gt;
      end
   end

   // insertion: keep, take from below, or take the new sample
   always_comb begin
      if (!self_gt) begin
         value_in = self_value;
         age_in   = self_age + AGE_ONE;
      end else if (low_gt) begin
         value_in = low_value;
         age_in   = low_age + AGE_ONE;
      end else begin
         value_in = sample;
         age_in   = '0;
      end
      next_value = value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         age_ff   <= reset_age;
      end else if (enable) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/smf_checker.sv
`default_nettype none
`include "sliding_median_filter_unit_defines.svh"
// Port-level checks on the filter.
module smf_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire smf_pkg::sample_type rsp_tdata
);
   import smf_pkg::*;

   logic req_fire, rsp_stall;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // every item taken yields a result in the next cycle
   `SMF_ASSERT_NEXT(a_result_follows, req_fire, rsp_tvalid)
   // a waiting result blocks new items so none is overwritten
   `SMF_ASSERT_NOW(a_no_overwrite, rsp_stall, !req_tready)
   // no result without an item taken the cycle before
   `SMF_ASSERT_NEXT(a_no_invent, !req_fire && !rsp_stall, !rsp_tvalid)
   // a stalled result holds its value
   `SMF_ASSERT_NEXT(a_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
